### src/gcl_pkg.sv
// ----------------------------------------------------------------------------
// gcl_pkg: shared definitions of the grid component labeler
// Item kinds, register indexes, field widths and the flood FIFO control group.
// ----------------------------------------------------------------------------
`default_nettype none

package gcl_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  // Label width, coordinate width (holds up to 511) and register width.
  localparam int LBL_W = 12;
  localparam int CRD_W = 9;
  localparam int REG_W = 7;
  localparam int IDX_W = 2;

  localparam logic [LBL_W-1:0] LABEL_MAX = '1;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [REG_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctl_t;

  // A dimension register of 0 counts as 1, and one above the maximum saturates.
  function automatic logic [CRD_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                input logic [CRD_W-1:0] maxv);
    logic [CRD_W-1:0] w;
    w = CRD_W'(v);
    if (v == '0) return CRD_W'(1);
    if (w > maxv) return maxv;
    return w;
  endfunction

endpackage

`default_nettype wire

### src/gcl_flood_fifo.sv
// ----------------------------------------------------------------------------
// gcl_flood_fifo: breadth-first work queue of the flood fill
// A memory with a head and a tail pointer; popped data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gcl_flood_fifo
  import gcl_pkg::*;
#(
  parameter int DEPTH  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  parameter int DATA_W = 12
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fifo_ctl_t         ctl,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata,
  output logic                   empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW:0]       head_r, head_nxt;
  logic [AW:0]       tail_r, tail_nxt;
  logic [DATA_W-1:0] rdata_r;

  assign empty = (head_r == tail_r);
  assign rdata = rdata_r;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      if (ctl.pop)  head_nxt = head_r + 1'b1;
      if (ctl.push) tail_nxt = tail_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) mem[tail_r[AW-1:0]] <= wdata;
    if (ctl.pop)  rdata_r <= mem[head_r[AW-1:0]];
  end

endmodule

`default_nettype wire

### src/grid_component_labeler_top.sv
// ----------------------------------------------------------------------------
// grid_component_labeler_top: 4-connected component labeler of an obstacle grid
// Holds obstacle bits and component labels in one cell memory and relabels on
// demand with a breadth-first flood.
// ----------------------------------------------------------------------------
// Each input transaction writes one cell's obstacle bit, clears the whole grid
// or queries a cell, and gives exactly one result transaction. Cell memory
// words hold the obstacle bit above a 12-bit label; a label of zero marks a
// cell the flood has not reached yet, so no separate visited store exists.
// The block handles one transaction at a time, and the cell memory has a
// single read port. After reset a clearing pass over all N cells
// (N = MAX_WIDTH*MAX_HEIGHT) empties the grid before the first input is
// taken; a clear item runs the same pass before its result. A query after
// a write, a clear or a register write first relabels: it zeroes all labels,
// then scans each cell of the configured grid. Each free unlabeled cell
// starts a new component and is queued; each dequeued cell has its neighbors
// inside the grid read, and free unlabeled ones are labeled and queued, until
// the queue is found empty. Finally the queried cell is read; a query on
// current labels reads it directly. The configuration port is always ready;
// it should be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_component_labeler_top
  import gcl_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Input transactions.
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [15:0]      in_tdata,   // cell_x[5:0], cell_y[11:6], obstacle_bit[12]
  input  wire logic [1:0]       in_tuser,   // kind[1:0]
  // Result transactions.
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [15:0]      out_tdata,  // is_blocked[0], component[12:1]
  output logic                  out_tuser,  // status[0]
  // Register writes.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [REG_W-1:0] cfg_data
);

  localparam int N  = MAX_WIDTH * MAX_HEIGHT;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QW = XW + YW;
  localparam int MW = LBL_W + 1;
  localparam logic [CRD_W-1:0] MAXW = CRD_W'(MAX_WIDTH);
  localparam logic [CRD_W-1:0] MAXH = CRD_W'(MAX_HEIGHT);
  localparam logic [IW:0]      NCELL = (IW+1)'(N);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_LCLR, S_SCAN_RD, S_SCAN_CK, S_Q_RD, S_Q_WAIT,
    S_N_RD, S_N_CK, S_QRD, S_QOUT
  } state_t;

  function automatic logic [IW-1:0] cell_idx(input logic [CRD_W-1:0] x,
                                             input logic [CRD_W-1:0] y);
    logic [31:0] t;
    t = 32'(y) * MAX_WIDTH + 32'(x);
    return t[IW-1:0];
  endfunction

  // Cell memory: obstacle bit on top, label below.
  logic [MW-1:0] cell_mem [N];
  logic [MW-1:0] cell_q_r;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) cell_mem[wr_addr] <= wr_data;
    if (rd_en) cell_q_r <= cell_mem[rd_addr];
  end

  // Flood queue.
  fifo_ctl_t     fctl;
  logic [QW-1:0] f_wdata;
  logic [QW-1:0] f_rdata;
  logic          f_empty;

  gcl_flood_fifo #(
    .DEPTH  (N),
    .DATA_W (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (fctl),
    .wdata (f_wdata),
    .rdata (f_rdata),
    .empty (f_empty)
  );

  state_t           state_r, state_nxt;
  logic [IW:0]      ptr_r, ptr_nxt;
  logic [IW-1:0]    pd_r, pd_nxt;
  logic             pend_r, pend_nxt;
  logic             clr_item_r, clr_item_nxt;
  logic [CRD_W-1:0] gw_r, gw_nxt, gh_r, gh_nxt;
  logic             lbl_ok_r, lbl_ok_nxt;
  logic [LBL_W-1:0] cnt_r, cnt_nxt;
  logic [CRD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic [CRD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [CRD_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [1:0]       nb_r, nb_nxt;
  logic [CRD_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_blk_r, out_blk_nxt;
  logic [LBL_W-1:0] out_comp_r, out_comp_nxt;

  // Input fields.
  logic [1:0]       in_kind;
  logic [CRD_W-1:0] in_x, in_y;
  logic             in_bit;
  logic             in_fire, in_grid;

  assign in_kind = in_tuser;
  assign in_x    = CRD_W'(in_tdata[5:0]);
  assign in_y    = CRD_W'(in_tdata[11:6]);
  assign in_bit  = in_tdata[12];
  assign in_grid = (in_x < gw_r) && (in_y < gh_r);

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_comp_r, out_blk_r};
  assign out_tuser  = out_status_r;

  // Neighbor selection of the flood.
  logic             nb_ok;
  logic [CRD_W-1:0] nb_x, nb_y;

  always_comb begin
    nb_x  = cx_r;
    nb_y  = cy_r;
    nb_ok = 1'b0;
    case (nb_r)
      2'd0: begin
        nb_ok = (cx_r != '0);
        nb_x  = cx_r - 1'b1;
      end
      2'd1: begin
        nb_ok = (cx_r + 1'b1 < gw_r);
        nb_x  = cx_r + 1'b1;
      end
      2'd2: begin
        nb_ok = (cy_r != '0);
        nb_y  = cy_r - 1'b1;
      end
      default: begin
        nb_ok = (cy_r + 1'b1 < gh_r);
        nb_y  = cy_r + 1'b1;
      end
    endcase
  end

  logic             cell_new;
  logic [LBL_W-1:0] cnt_inc;

  assign cell_new = !cell_q_r[LBL_W] && (cell_q_r[LBL_W-1:0] == '0);
  assign cnt_inc  = (cnt_r == LABEL_MAX) ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    pd_nxt         = pd_r;
    pend_nxt       = pend_r;
    clr_item_nxt   = clr_item_r;
    gw_nxt         = gw_r;
    gh_nxt         = gh_r;
    lbl_ok_nxt     = lbl_ok_r;
    cnt_nxt        = cnt_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    nb_nxt         = nb_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_comp_nxt   = out_comp_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    fctl           = '0;
    f_wdata        = '0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          gw_nxt     = clamp_dim(cfg_data, MAXW);
          lbl_ok_nxt = 1'b0;
        end
        REG_GRID_HEIGHT: begin
          gh_nxt     = clamp_dim(cfg_data, MAXH);
          lbl_ok_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      S_CLR: begin
        if (ptr_r < NCELL) begin
          wr_en   = 1'b1;
          wr_addr = ptr_r[IW-1:0];
          ptr_nxt = ptr_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
          if (clr_item_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            out_blk_nxt    = 1'b0;
            out_comp_nxt   = '0;
          end
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          out_status_nxt = 1'b0;
          out_blk_nxt    = 1'b0;
          out_comp_nxt   = '0;
          case (in_kind)
            KIND_WRITE: begin
              out_valid_nxt = 1'b1;
              if (in_grid) begin
                wr_en      = 1'b1;
                wr_addr    = cell_idx(in_x, in_y);
                wr_data    = {in_bit, {LBL_W{1'b0}}};
                lbl_ok_nxt = 1'b0;
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            KIND_CLEAR: begin
              lbl_ok_nxt   = 1'b0;
              clr_item_nxt = 1'b1;
              ptr_nxt      = '0;
              state_nxt    = S_CLR;
            end
            KIND_QUERY: begin
              qx_nxt = in_x;
              qy_nxt = in_y;
              if (!in_grid) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = 1'b1;
              end else if (lbl_ok_r) begin
                state_nxt = S_QRD;
              end else begin
                ptr_nxt   = '0;
                pend_nxt  = 1'b0;
                cnt_nxt   = '0;
                fctl.clear = 1'b1;
                state_nxt = S_LCLR;
              end
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end

      // Zero every label and keep the obstacle bits.
      S_LCLR: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pd_r;
          wr_data = {cell_q_r[LBL_W], {LBL_W{1'b0}}};
        end
        if (ptr_r < NCELL) begin
          rd_en    = 1'b1;
          rd_addr  = ptr_r[IW-1:0];
          pd_nxt   = ptr_r[IW-1:0];
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            sx_nxt    = '0;
            sy_nxt    = '0;
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        rd_en     = 1'b1;
        rd_addr   = cell_idx(sx_r, sy_r);
        state_nxt = S_SCAN_CK;
      end

      S_SCAN_CK, S_Q_RD: begin
        if (state_r == S_SCAN_CK && cell_new) begin
          cnt_nxt   = cnt_inc;
          wr_en     = 1'b1;
          wr_addr   = cell_idx(sx_r, sy_r);
          wr_data   = {1'b0, cnt_inc};
          fctl.push = 1'b1;
          f_wdata   = {sy_r[YW-1:0], sx_r[XW-1:0]};
          state_nxt = S_Q_RD;
        end else if (state_r == S_Q_RD && !f_empty) begin
          fctl.pop  = 1'b1;
          state_nxt = S_Q_WAIT;
        end else if (sx_r + 1'b1 < gw_r) begin
          sx_nxt    = sx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else if (sy_r + 1'b1 < gh_r) begin
          sx_nxt    = '0;
          sy_nxt    = sy_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          lbl_ok_nxt = 1'b1;
          state_nxt  = S_QRD;
        end
      end

      S_Q_WAIT: begin
        cx_nxt    = CRD_W'(f_rdata[XW-1:0]);
        cy_nxt    = CRD_W'(f_rdata[QW-1:XW]);
        nb_nxt    = '0;
        state_nxt = S_N_RD;
      end

      S_N_RD: begin
        if (nb_ok) begin
          rd_en     = 1'b1;
          rd_addr   = cell_idx(nb_x, nb_y);
          nx_nxt    = nb_x;
          ny_nxt    = nb_y;
          state_nxt = S_N_CK;
        end else begin
          nb_nxt    = nb_r + 1'b1;
          state_nxt = (nb_r == 2'd3) ? S_Q_RD : S_N_RD;
        end
      end

      S_N_CK: begin
        if (cell_new) begin
          wr_en     = 1'b1;
          wr_addr   = cell_idx(nx_r, ny_r);
          wr_data   = {1'b0, cnt_r};
          fctl.push = 1'b1;
          f_wdata   = {ny_r[YW-1:0], nx_r[XW-1:0]};
        end
        nb_nxt    = nb_r + 1'b1;
        state_nxt = (nb_r == 2'd3) ? S_Q_RD : S_N_RD;
      end

      S_QRD: begin
        rd_en     = 1'b1;
        rd_addr   = cell_idx(qx_r, qy_r);
        state_nxt = S_QOUT;
      end

      S_QOUT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_blk_nxt    = cell_q_r[LBL_W];
        out_comp_nxt   = cell_q_r[LBL_W] ? '0 : cell_q_r[LBL_W-1:0];
        state_nxt      = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      clr_item_r  <= 1'b0;
      gw_r        <= clamp_dim(DIM_RESET, MAXW);
      gh_r        <= clamp_dim(DIM_RESET, MAXH);
      lbl_ok_r    <= 1'b0;
      cnt_r       <= '0;
      nb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      clr_item_r  <= clr_item_nxt;
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
      lbl_ok_r    <= lbl_ok_nxt;
      cnt_r       <= cnt_nxt;
      nb_r        <= nb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pd_r         <= pd_nxt;
    sx_r         <= sx_nxt;
    sy_r         <= sy_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    nx_r         <= nx_nxt;
    ny_r         <= ny_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_comp_r   <= out_comp_nxt;
  end

endmodule

`default_nettype wire
